// ----- rtl/adl_pkg.sv -----
`timescale 1ns / 1ps

package adl_pkg;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EPOCH_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_WEIGHT_1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_WEIGHT_2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_BIAS      = 3'd5;

    // Register values after reset.
    localparam logic [15:0] RST_LEARNING_RATE  = 16'd6554;
    localparam logic [31:0] RST_STOP_THRESHOLD = 32'd91750;
    localparam logic [7:0]  RST_EPOCH_LIMIT    = 8'd50;
    localparam logic [31:0] RST_INIT_WEIGHT    = 32'd6554;

    // Default sizing handed down from the top level.
    localparam int SAMPLES_PER_EPOCH_DEF = 4;
    localparam int QUEUE_DEPTH_DEF       = 2;

    // A sample as classified by the front end: the target is already in Q7.16.
    typedef struct packed {
        logic [7:0]  x_one;
        logic [7:0]  x_two;
        logic [23:0] target_q;
    } t_sample;

    typedef struct packed {
        logic [31:0] net_value;
        logic [31:0] error_value;
        logic [31:0] weight_one_now;
        logic [31:0] weight_two_now;
        logic [31:0] bias_now;
        logic [31:0] squared_error;
        logic [31:0] epoch_error_sum;
        logic        epoch_end;
        logic [7:0]  epoch_number;
        logic        training_done;
    } t_result;

    typedef struct packed {
        logic                  en;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

// ----- rtl/adl_fifo.sv -----
`timescale 1ns / 1ps

// Small show-ahead queue. DEPTH must be a power of two, at least two.
module adl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_full,
    input  logic             i_rd_en,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [AW:0]      r_wr_ptr;
    logic [AW:0]      r_rd_ptr;

    assign o_empty   = (r_wr_ptr == r_rd_ptr);
    assign o_full    = (r_wr_ptr[AW] != r_rd_ptr[AW]) &&
                       (r_wr_ptr[AW-1:0] == r_rd_ptr[AW-1:0]);
    assign o_rd_data = r_slot[r_rd_ptr[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_wr_en && !o_full) begin
                r_wr_ptr <= r_wr_ptr + (AW+1)'(1);
            end
            if (i_rd_en && !o_empty) begin
                r_rd_ptr <= r_rd_ptr + (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && !o_full) begin
            r_slot[r_wr_ptr[AW-1:0]] <= i_wr_data;
        end
    end

endmodule

// ----- rtl/adl_front.sv -----
`timescale 1ns / 1ps

// Input stage: takes a sample beat, scales the target to Q7.16 and hands the
// sample on to the work queue.
module adl_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  logic [7:0]      i_x_one,
    input  logic [7:0]      i_x_two,
    input  logic [7:0]      i_target,
    output logic            o_q_wr_en,
    output adl_pkg::t_sample o_q_wr_data,
    input  logic            i_q_full
);

    logic             r_vld;
    adl_pkg::t_sample r_item;
    logic             accept;
    logic             move;
    logic             n_vld;

    assign move        = r_vld && !i_q_full;
    assign o_full      = r_vld && i_q_full;
    assign accept      = i_push && !o_full;
    assign n_vld       = accept || (r_vld && !move);
    assign o_q_wr_en   = move;
    assign o_q_wr_data = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.x_one    <= i_x_one;
            r_item.x_two    <= i_x_two;
            r_item.target_q <= {i_target, 16'd0};
        end
    end

endmodule

// ----- rtl/adl_back.sv -----
`timescale 1ns / 1ps

// Training engine: a sequencer that walks one sample through the dependent
// multiplies, then updates the weights and the epoch bookkeeping.
module adl_back #(
    parameter int SAMPLES_PER_EPOCH = adl_pkg::SAMPLES_PER_EPOCH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  adl_pkg::t_cfg_wr i_cfg,
    input  logic             i_q_empty,
    input  adl_pkg::t_sample i_q_data,
    output logic             o_q_pop,
    input  logic             i_out_full,
    output logic             o_out_push,
    output adl_pkg::t_result o_out_data
);

    localparam int CNT_W = (SAMPLES_PER_EPOCH > 1) ? $clog2(SAMPLES_PER_EPOCH) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_EPOCH - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PROD  = 3'd1;
    localparam logic [2:0] ST_NET   = 3'd2;
    localparam logic [2:0] ST_ERR   = 3'd3;
    localparam logic [2:0] ST_SQ    = 3'd4;
    localparam logic [2:0] ST_DELTA = 3'd5;
    localparam logic [2:0] ST_UPD   = 3'd6;

    function automatic logic [31:0] sat32(input logic [41:0] v);
        logic [31:0] res;
        if (!v[41] && (|v[40:31])) begin
            res = 32'h7FFF_FFFF;
        end else if (v[41] && !(&v[40:31])) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Control and configuration state.
    logic [2:0]       r_state;
    logic [15:0]      r_rate;
    logic [31:0]      r_thresh;
    logic [7:0]       r_limit;
    logic [31:0]      r_w1;
    logic [31:0]      r_w2;
    logic [31:0]      r_wb;
    logic [31:0]      r_acc;
    logic [CNT_W-1:0] r_cnt;
    logic [7:0]       r_epoch;
    logic             r_stopped;

    // Working registers of the sample in flight.
    logic [7:0]  r_x1;
    logic [7:0]  r_x2;
    logic [23:0] r_tg;
    logic [39:0] r_p1;
    logic [39:0] r_p2;
    logic [31:0] r_net;
    logic [31:0] r_err;
    logic [63:0] r_sqf;
    logic [47:0] r_re;
    logic [55:0] r_d1;
    logic [55:0] r_d2;
    logic [31:0] r_sq;

    logic [41:0] net_sum;
    logic [32:0] err_diff;
    logic [63:0] sq_rnd;
    logic [56:0] d1_rnd;
    logic [56:0] d2_rnd;
    logic [48:0] re_rnd;
    logic [41:0] w1_sum;
    logic [41:0] w2_sum;
    logic [41:0] wb_sum;
    logic [32:0] acc_sum;
    logic [31:0] new_sum;
    logic [7:0]  epoch_next;
    logic [7:0]  limit_eff;
    logic        last_sample;
    logic        stop_now;
    logic [31:0] upd_w1;
    logic [31:0] upd_w2;
    logic [31:0] upd_wb;

    always_comb begin
        net_sum  = {{2{r_p1[39]}}, r_p1} + {{2{r_p2[39]}}, r_p2} + {{10{r_wb[31]}}, r_wb};
        err_diff = {{9{r_tg[23]}}, r_tg} - {r_net[31], r_net};
        sq_rnd   = r_sqf + 64'd32768;

        // Round to Q.16 by adding one half and taking the floor.
        d1_rnd = {r_d1[55], r_d1} + 57'd32768;
        d2_rnd = {r_d2[55], r_d2} + 57'd32768;
        re_rnd = {r_re[47], r_re} + 49'd32768;
        w1_sum = {{10{r_w1[31]}}, r_w1} + {d1_rnd[56], d1_rnd[56:16]};
        w2_sum = {{10{r_w2[31]}}, r_w2} + {d2_rnd[56], d2_rnd[56:16]};
        wb_sum = {{10{r_wb[31]}}, r_wb} + {{9{re_rnd[48]}}, re_rnd[48:16]};
        upd_w1 = r_stopped ? r_w1 : sat32(w1_sum);
        upd_w2 = r_stopped ? r_w2 : sat32(w2_sum);
        upd_wb = r_stopped ? r_wb : sat32(wb_sum);

        acc_sum     = {1'b0, r_acc} + {1'b0, r_sq};
        new_sum     = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
        epoch_next  = (r_epoch == 8'hFF) ? r_epoch : r_epoch + 8'd1;
        limit_eff   = (r_limit == 8'd0) ? 8'd1 : r_limit;
        last_sample = !r_stopped && (r_cnt == CNT_LAST);
        stop_now    = last_sample && ((new_sum < r_thresh) || (epoch_next >= limit_eff));
    end

    assign o_q_pop    = (r_state == ST_IDLE) && !i_q_empty && !i_out_full;
    assign o_out_push = (r_state == ST_UPD);

    always_comb begin
        o_out_data.net_value       = r_net;
        o_out_data.error_value     = r_err;
        o_out_data.weight_one_now  = upd_w1;
        o_out_data.weight_two_now  = upd_w2;
        o_out_data.bias_now        = upd_wb;
        o_out_data.squared_error   = r_sq;
        o_out_data.epoch_error_sum = r_stopped ? r_acc : new_sum;
        o_out_data.epoch_end       = last_sample;
        o_out_data.epoch_number    = r_epoch;
        o_out_data.training_done   = r_stopped || stop_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rate    <= adl_pkg::RST_LEARNING_RATE;
            r_thresh  <= adl_pkg::RST_STOP_THRESHOLD;
            r_limit   <= adl_pkg::RST_EPOCH_LIMIT;
            r_w1      <= adl_pkg::RST_INIT_WEIGHT;
            r_w2      <= adl_pkg::RST_INIT_WEIGHT;
            r_wb      <= adl_pkg::RST_INIT_WEIGHT;
            r_acc     <= '0;
            r_cnt     <= '0;
            r_epoch   <= '0;
            r_stopped <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (o_q_pop) begin
                        r_state <= ST_PROD;
                    end
                end
                ST_PROD:  r_state <= ST_NET;
                ST_NET:   r_state <= ST_ERR;
                ST_ERR:   r_state <= ST_SQ;
                ST_SQ:    r_state <= ST_DELTA;
                ST_DELTA: r_state <= ST_UPD;
                ST_UPD: begin
                    r_state <= ST_IDLE;
                    if (!r_stopped) begin
                        r_w1 <= upd_w1;
                        r_w2 <= upd_w2;
                        r_wb <= upd_wb;
                        if (last_sample) begin
                            r_cnt     <= '0;
                            r_acc     <= '0;
                            r_epoch   <= epoch_next;
                            r_stopped <= stop_now;
                        end else begin
                            r_cnt <= r_cnt + CNT_W'(1);
                            r_acc <= new_sum;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            // Configuration is written by the user only while idle, unenforced; it wins.
            if (i_cfg.en) begin
                case (i_cfg.index)
                    adl_pkg::CFG_LEARNING_RATE:  r_rate   <= i_cfg.data[15:0];
                    adl_pkg::CFG_STOP_THRESHOLD: r_thresh <= i_cfg.data;
                    adl_pkg::CFG_EPOCH_LIMIT:    r_limit  <= i_cfg.data[7:0];
                    adl_pkg::CFG_INIT_WEIGHT_1:  r_w1     <= i_cfg.data;
                    adl_pkg::CFG_INIT_WEIGHT_2:  r_w2     <= i_cfg.data;
                    adl_pkg::CFG_INIT_BIAS:      r_wb     <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_x1 <= i_q_data.x_one;
                r_x2 <= i_q_data.x_two;
                r_tg <= i_q_data.target_q;
            end
            ST_PROD: begin
                r_p1 <= {{32{r_x1[7]}}, r_x1} * {{8{r_w1[31]}}, r_w1};
                r_p2 <= {{32{r_x2[7]}}, r_x2} * {{8{r_w2[31]}}, r_w2};
            end
            ST_NET: begin
                r_net <= sat32(net_sum);
            end
            ST_ERR: begin
                r_err <= sat32({{9{err_diff[32]}}, err_diff});
            end
            ST_SQ: begin
                r_sqf <= {{32{r_err[31]}}, r_err} * {{32{r_err[31]}}, r_err};
                r_re  <= {32'd0, r_rate} * {{16{r_err[31]}}, r_err};
            end
            ST_DELTA: begin
                r_d1 <= {{8{r_re[47]}}, r_re} * {{48{r_x1[7]}}, r_x1};
                r_d2 <= {{8{r_re[47]}}, r_re} * {{48{r_x2[7]}}, r_x2};
                r_sq <= (|sq_rnd[63:48]) ? 32'hFFFF_FFFF : sq_rnd[47:16];
            end
            default: ;
        endcase
    end

endmodule

// ----- rtl/adaline_lms_trainer.sv -----
`timescale 1ns / 1ps

// Two-input Adaline trained by the LMS delta rule, one sample per beat.
// Samples enter through a queue-style port: a beat is taken when push is high
// and full is low. Results leave the same way: the oldest result sits on the
// o_ result ports while empty is low and is taken when pop is high.
// Configuration registers are written over their own valid/ready channel,
// which is always ready; writes are meant for times when no sample is in
// flight. Writing an initial weight loads it into the live weight at once.
// A sample that leaves the work queue walks the single training sequencer
// through PROD, NET, ERR, SQ and DELTA, the chain of dependent multiplies,
// and is queued as a result in UPD; the sequencer then returns to IDLE
// before it takes the next sample, so samples are handled one at a time.
// Reset (synchronous, active low) restores the register defaults, loads the
// initial weights and clears the epoch sum, the counters and the done flag.
// When the receiver stalls, up to QUEUE_DEPTH results wait in the result
// queue; then the engine holds, the work queue and the input stage fill, and
// full rises. No beat is dropped.
module adaline_lms_trainer #(
    parameter int SAMPLES_PER_EPOCH = adl_pkg::SAMPLES_PER_EPOCH_DEF,
    parameter int QUEUE_DEPTH       = adl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     i_sample_x_one,
    input  logic [7:0]                     i_sample_x_two,
    input  logic [7:0]                     i_sample_target,
    output logic                           empty,
    input  logic                           pop,
    output logic [31:0]                    o_net_value,
    output logic [31:0]                    o_error_value,
    output logic [31:0]                    o_weight_one_now,
    output logic [31:0]                    o_weight_two_now,
    output logic [31:0]                    o_bias_now,
    output logic [31:0]                    o_squared_error,
    output logic [31:0]                    o_epoch_error_sum,
    output logic                           o_epoch_end,
    output logic [7:0]                     o_epoch_number,
    output logic                           o_training_done,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [adl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [adl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SAMPLE_W = $bits(adl_pkg::t_sample);
    localparam int RESULT_W = $bits(adl_pkg::t_result);

    adl_pkg::t_sample front_data;
    adl_pkg::t_sample work_data;
    adl_pkg::t_result back_data;
    adl_pkg::t_result res_data;
    adl_pkg::t_cfg_wr cfg_wr;
    logic             front_wr;
    logic             work_full;
    logic             work_empty;
    logic             work_pop;
    logic             res_push;
    logic             res_full;

    // The configuration channel never back-pressures.
    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.en    = i_cfg_valid && o_cfg_ready;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    // Front end: one input register ahead of the work queue.
    adl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_x_one     (i_sample_x_one),
        .i_x_two     (i_sample_x_two),
        .i_target    (i_sample_target),
        .o_q_wr_en   (front_wr),
        .o_q_wr_data (front_data),
        .i_q_full    (work_full)
    );

    // Work queue decoupling the front end from the training engine.
    adl_fifo #(
        .WIDTH (SAMPLE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_work_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (front_wr),
        .i_wr_data (front_data),
        .o_full    (work_full),
        .i_rd_en   (work_pop),
        .o_rd_data (work_data),
        .o_empty   (work_empty)
    );

    // The engine only starts a sample when the result queue has room, so a
    // finished result never has to wait inside the sequencer.
    adl_back #(
        .SAMPLES_PER_EPOCH (SAMPLES_PER_EPOCH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg_wr),
        .i_q_empty  (work_empty),
        .i_q_data   (work_data),
        .o_q_pop    (work_pop),
        .i_out_full (res_full),
        .o_out_push (res_push),
        .o_out_data (back_data)
    );

    // Result queue facing the receiver.
    adl_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (res_push),
        .i_wr_data (back_data),
        .o_full    (res_full),
        .i_rd_en   (pop),
        .o_rd_data (res_data),
        .o_empty   (empty)
    );

    assign o_net_value       = res_data.net_value;
    assign o_error_value     = res_data.error_value;
    assign o_weight_one_now  = res_data.weight_one_now;
    assign o_weight_two_now  = res_data.weight_two_now;
    assign o_bias_now        = res_data.bias_now;
    assign o_squared_error   = res_data.squared_error;
    assign o_epoch_error_sum = res_data.epoch_error_sum;
    assign o_epoch_end       = res_data.epoch_end;
    assign o_epoch_number    = res_data.epoch_number;
    assign o_training_done   = res_data.training_done;

    // A finished result must always find room in the result queue.
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result written into a full result queue");

    // The engine must never take a sample from an empty work queue.
    a_work_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        work_pop |-> !work_empty)
        else $error("sample taken from an empty work queue");

    // One sample at a time: results are never written in consecutive cycles.
    a_seq_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |=> !res_push)
        else $error("results written on consecutive cycles");

    // Starting a sample and finishing one never coincide.
    a_start_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !work_pop)
        else $error("sample started while another finished");

endmodule

// ----- bench/adl_lms_checker.sv -----
`timescale 1ns / 1ps

module adl_lms_checker #(
    parameter int SAMPLES_PER_EPOCH = adl_pkg::SAMPLES_PER_EPOCH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    input  logic                           full,
    input  logic [7:0]                     x_one,
    input  logic [7:0]                     x_two,
    input  logic [7:0]                     target,
    input  logic                           empty,
    input  logic                           pop,
    input  adl_pkg::t_result               result,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [adl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [adl_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             updates_pending,
    output int                             mismatches
);

    localparam longint Q_MAX  = 64'sd2147483647;
    localparam longint Q_MIN  = -64'sd2147483648;
    localparam longint SQ_MAX = 64'sd4294967295;

    logic [15:0]      rate;
    logic [31:0]      threshold;
    logic [7:0]       limit;
    longint           w_one;
    longint           w_two;
    longint           w_bias;
    logic [31:0]      err_sum;
    int               sample_cnt;
    logic [7:0]       epoch_cnt;
    logic             stopped;
    adl_pkg::t_result due_updates[$];

    function automatic longint sat_q(input longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    // Q.32 to Q.16: add half an LSB, then floor.
    function automatic longint round_q16(input longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    // One delta-rule step on the trainer state; returns the result beat it should produce.
    function automatic adl_pkg::t_result lms_update(input logic [7:0] a, input logic [7:0] b,
                                                    input logic [7:0] c);
        longint           x1, x2, tg, net, err, sq, rate_err;
        logic [31:0]      sq32, sum;
        logic [7:0]       epoch_idx, lim;
        logic             closes;
        adl_pkg::t_result r;
        x1 = $signed(a);
        x2 = $signed(b);
        tg = $signed(c);
        net = sat_q(x1 * w_one + x2 * w_two + w_bias);
        err = sat_q(tg * 65536 - net);
        sq = round_q16(err * err);
        sq32 = (sq > SQ_MAX) ? 32'hFFFF_FFFF : sq[31:0];
        sum = err_sum;
        epoch_idx = epoch_cnt;
        closes = 1'b0;
        if (!stopped) begin
            rate_err = rate;
            rate_err = rate_err * err;
            w_one = sat_q(w_one + round_q16(rate_err * x1));
            w_two = sat_q(w_two + round_q16(rate_err * x2));
            w_bias = sat_q(w_bias + round_q16(rate_err));
            sum = (32'hFFFF_FFFF - err_sum < sq32) ? 32'hFFFF_FFFF : err_sum + sq32;
            err_sum = sum;
            sample_cnt++;
            if (sample_cnt >= SAMPLES_PER_EPOCH) begin
                // A zero limit behaves as a limit of one epoch.
                lim = (limit == 8'd0) ? 8'd1 : limit;
                closes = 1'b1;
                if (epoch_cnt != 8'hFF) epoch_cnt++;
                if (sum < threshold || epoch_cnt >= lim) stopped = 1'b1;
                sample_cnt = 0;
                err_sum = '0;
            end
        end
        r.net_value       = net[31:0];
        r.error_value     = err[31:0];
        r.weight_one_now  = w_one[31:0];
        r.weight_two_now  = w_two[31:0];
        r.bias_now        = w_bias[31:0];
        r.squared_error   = sq32;
        r.epoch_error_sum = sum;
        r.epoch_end       = closes;
        r.epoch_number    = epoch_idx;
        r.training_done   = stopped;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        adl_pkg::t_result want;
        if (!i_rst_n) begin
            rate       = adl_pkg::RST_LEARNING_RATE;
            threshold  = adl_pkg::RST_STOP_THRESHOLD;
            limit      = adl_pkg::RST_EPOCH_LIMIT;
            w_one      = $signed(adl_pkg::RST_INIT_WEIGHT);
            w_two      = $signed(adl_pkg::RST_INIT_WEIGHT);
            w_bias     = $signed(adl_pkg::RST_INIT_WEIGHT);
            err_sum    = '0;
            sample_cnt = 0;
            epoch_cnt  = '0;
            stopped    = 1'b0;
            due_updates.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    adl_pkg::CFG_LEARNING_RATE:  rate = cfg_data[15:0];
                    adl_pkg::CFG_STOP_THRESHOLD: threshold = cfg_data;
                    adl_pkg::CFG_EPOCH_LIMIT:    limit = cfg_data[7:0];
                    adl_pkg::CFG_INIT_WEIGHT_1:  w_one = $signed(cfg_data);
                    adl_pkg::CFG_INIT_WEIGHT_2:  w_two = $signed(cfg_data);
                    adl_pkg::CFG_INIT_BIAS:      w_bias = $signed(cfg_data);
                    default: ;
                endcase
            end
            // Results are checked before this edge's sample is predicted, so a result
            // cannot be matched against a sample taken at the same edge.
            if (pop && !empty) begin
                if (due_updates.size() == 0) begin
                    $error("result beat arrived with no sample outstanding");
                    mismatches++;
                end else begin
                    want = due_updates.pop_front();
                    check_field("net_value", want.net_value, result.net_value);
                    check_field("error_value", want.error_value, result.error_value);
                    check_field("weight_one_now", want.weight_one_now, result.weight_one_now);
                    check_field("weight_two_now", want.weight_two_now, result.weight_two_now);
                    check_field("bias_now", want.bias_now, result.bias_now);
                    check_field("squared_error", want.squared_error, result.squared_error);
                    check_field("epoch_error_sum", want.epoch_error_sum,
                                result.epoch_error_sum);
                    check_field("epoch_end", 32'(want.epoch_end), 32'(result.epoch_end));
                    check_field("epoch_number", 32'(want.epoch_number),
                                32'(result.epoch_number));
                    check_field("training_done", 32'(want.training_done),
                                32'(result.training_done));
                end
            end
            if (push && !full) due_updates.push_back(lms_update(x_one, x_two, target));
        end
        updates_pending = due_updates.size();
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the Adaline trainer. The checker beside the block
// watches every beat and predicts the results; this module only drives the
// three channels and decides pass or fail at the end.
module tb_top;

    // Indexes that no register answers to; writes to them must change nothing.
    localparam logic [adl_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [adl_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int TRAIN_PHASES  = 12;
    localparam int PHASE_SAMPLES = 64;
    localparam int PRESSURE_PH   = 5;
    localparam int HOLD_OFF      = 300;
    localparam int DRAIN_CYCLES  = 20;

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           push       = 1'b0;
    logic                           full;
    logic [7:0]                     x_one      = '0;
    logic [7:0]                     x_two      = '0;
    logic [7:0]                     target     = '0;
    logic                           empty;
    logic                           pop        = 1'b0;
    logic [31:0]                    net_value;
    logic [31:0]                    error_value;
    logic [31:0]                    weight_one_now;
    logic [31:0]                    weight_two_now;
    logic [31:0]                    bias_now;
    logic [31:0]                    squared_error;
    logic [31:0]                    epoch_error_sum;
    logic                           epoch_end;
    logic [7:0]                     epoch_number;
    logic                           training_done;
    logic                           cfg_valid  = 1'b0;
    logic                           cfg_ready;
    logic [adl_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [adl_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

    int updates_pending;
    int mismatches;

    // Idling odds, in percent per cycle, and the receiver's long hold-off.
    int send_idle   = 0;
    int recv_stall  = 0;
    int hold_cycles = 0;

    // The line the well-formed samples are drawn from: target = ta*x1 + tb*x2 + tc.
    int ta = 1;
    int tb = 1;
    int tc = 0;
    int span = 2;

    adaline_lms_trainer u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_sample_x_one    (x_one),
        .i_sample_x_two    (x_two),
        .i_sample_target   (target),
        .empty             (empty),
        .pop               (pop),
        .o_net_value       (net_value),
        .o_error_value     (error_value),
        .o_weight_one_now  (weight_one_now),
        .o_weight_two_now  (weight_two_now),
        .o_bias_now        (bias_now),
        .o_squared_error   (squared_error),
        .o_epoch_error_sum (epoch_error_sum),
        .o_epoch_end       (epoch_end),
        .o_epoch_number    (epoch_number),
        .o_training_done   (training_done),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    adl_lms_checker u_lms_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .x_one           (x_one),
        .x_two           (x_two),
        .target          (target),
        .empty           (empty),
        .pop             (pop),
        .result          ({net_value, error_value, weight_one_now, weight_two_now,
                           bias_now, squared_error, epoch_error_sum, epoch_end,
                           epoch_number, training_done}),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .updates_pending (updates_pending),
        .mismatches      (mismatches)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop, far beyond the slowest legitimate run.
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver. All inputs move on the falling edge so that the block and the
    // checker both see settled values at the rising edge. A requested hold-off
    // is counted down here, one cycle at a time, and overrides the random stalls.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            pop = 1'b0;
            hold_cycles--;
        end else begin
            pop = ($urandom_range(99) >= recv_stall);
        end
    end

    // One register write beat. The channel is only used while no sample is in
    // flight, which the callers make sure of.
    task automatic write_reg(input logic [adl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        forever begin
            @(posedge i_clk);
            if (cfg_ready) break;
        end
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // One sample beat, preceded by a random number of idle cycles. Push stays
    // high from one beat into the next when no idle cycle falls between them.
    task automatic send_sample(input logic [7:0] a, input logic [7:0] b,
                               input logic [7:0] c);
        while ($urandom_range(99) < send_idle) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push   = 1'b1;
        x_one  = a;
        x_two  = b;
        target = c;
        forever begin
            @(posedge i_clk);
            if (!full) break;
        end
        @(negedge i_clk);
    endtask

    // Mostly samples that lie on the current line, so that training has
    // something to converge on, salted with samples of fully random bytes.
    task automatic send_training(input int count, input int noise_pct);
        int         k;
        int         xa;
        int         xb;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(99) < noise_pct) begin
                a = 8'($urandom);
                b = 8'($urandom);
                c = 8'($urandom);
            end else begin
                xa = int'($urandom_range(2 * span)) - span;
                xb = int'($urandom_range(2 * span)) - span;
                a = 8'(xa);
                b = 8'(xb);
                c = 8'(ta * xa + tb * xb + tc);
            end
            send_sample(a, b, c);
        end
    endtask

    // The sender stops and waits until every result it caused has been taken.
    task automatic drain();
        push = 1'b0;
        wait (updates_pending == 0);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom;
            default: return (int'($urandom_range(20)) - 10) <<< 16;
        endcase
    endfunction

    function automatic logic [15:0] pick_rate();
        case ($urandom_range(4))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(8000));
        endcase
    endfunction

    task automatic new_line();
        ta = int'($urandom_range(6)) - 3;
        tb = int'($urandom_range(6)) - 3;
        tc = int'($urandom_range(40)) - 20;
    endtask

    initial begin
        int ph;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Register defaults, extreme inputs. The errors are huge, so the epoch
        // sums stay far above the default threshold and training carries on;
        // the weights are driven into saturation.
        send_sample(8'h7F, 8'h7F, 8'h7F);
        send_sample(8'h80, 8'h80, 8'h80);
        send_sample(8'h00, 8'h00, 8'h00);
        send_sample(8'h7F, 8'h80, 8'h80);
        send_sample(8'h80, 8'h7F, 8'h7F);
        send_sample(8'h01, 8'hFF, 8'h00);
        send_sample(8'hFF, 8'h01, 8'hFF);
        send_sample(8'h7F, 8'h7F, 8'h80);
        drain();

        // Stopping is final until reset, and reset happens only once, so the
        // threshold is set where no sum can fall below it and the epoch limit
        // to its top. Training then runs through every phase below.
        write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_HI, 32'h0000_0000);
        write_reg(adl_pkg::CFG_STOP_THRESHOLD, 32'h0000_0000);
        write_reg(adl_pkg::CFG_EPOCH_LIMIT, 32'd255);

        for (ph = 0; ph < TRAIN_PHASES; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 49; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 49; end
                default: begin send_idle = 27; recv_stall = 27; end
            endcase
            new_line();
            write_reg(adl_pkg::CFG_LEARNING_RATE, {16'h0000, pick_rate()});
            write_reg(adl_pkg::CFG_INIT_WEIGHT_1, pick_weight());
            write_reg(adl_pkg::CFG_INIT_WEIGHT_2, pick_weight());
            write_reg(adl_pkg::CFG_INIT_BIAS, pick_weight());
            if (ph == PRESSURE_PH) begin
                // The receiver holds off for a long stretch while the sender
                // offers beats back to back, so the queues fill and full rises.
                // Half way through, the sender waits for everything to come back.
                send_idle   = 0;
                hold_cycles = HOLD_OFF;
                send_training(PHASE_SAMPLES / 2, 12);
                drain();
                send_training(PHASE_SAMPLES / 2, 12);
            end else begin
                send_training(PHASE_SAMPLES, 12);
            end
            drain();
        end

        // Stop training, either by the error threshold or by an epoch limit of
        // zero, which counts as a limit of one.
        send_idle  = 27;
        recv_stall = 27;
        if ($urandom_range(1) == 1) begin
            // Weights set exactly on the line and clean samples give zero error,
            // so the sum of the next whole epoch is below the default threshold.
            new_line();
            write_reg(adl_pkg::CFG_LEARNING_RATE, {16'h0000, adl_pkg::RST_LEARNING_RATE});
            write_reg(adl_pkg::CFG_STOP_THRESHOLD, adl_pkg::RST_STOP_THRESHOLD);
            write_reg(adl_pkg::CFG_INIT_WEIGHT_1, ta <<< 16);
            write_reg(adl_pkg::CFG_INIT_WEIGHT_2, tb <<< 16);
            write_reg(adl_pkg::CFG_INIT_BIAS, tc <<< 16);
            send_training(12, 0);
        end else begin
            write_reg(adl_pkg::CFG_EPOCH_LIMIT, 32'd0);
            send_training(12, 12);
        end
        drain();

        // After the stop the weights stay frozen except for direct loads, and
        // the remaining registers must no longer matter.
        write_reg(adl_pkg::CFG_EPOCH_LIMIT, 32'd1);
        write_reg(adl_pkg::CFG_STOP_THRESHOLD, 32'hFFFF_FFFF);
        write_reg(adl_pkg::CFG_LEARNING_RATE, 32'h0000_FFFF);
        write_reg(adl_pkg::CFG_INIT_WEIGHT_1, 32'h7FFF_FFFF);
        write_reg(adl_pkg::CFG_INIT_WEIGHT_2, 32'h8000_0000);
        write_reg(adl_pkg::CFG_INIT_BIAS, 32'h0000_0000);
        send_training(30, 50);
        drain();
        write_reg(adl_pkg::CFG_INIT_WEIGHT_1, pick_weight());
        write_reg(adl_pkg::CFG_INIT_WEIGHT_2, pick_weight());
        write_reg(adl_pkg::CFG_INIT_BIAS, pick_weight());
        send_training(30, 50);

        push = 1'b0;
        wait (updates_pending == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/adl_pkg.sv
rtl/adl_fifo.sv
rtl/adl_front.sv
rtl/adl_back.sv
rtl/adaline_lms_trainer.sv
bench/adl_lms_checker.sv
bench/tb_top.sv
